// ===== rtl/pscc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscc_pkg
// Shared constants and types for the polyline self-crossing check.
// ----------------------------------------------------------------------------
package pscc_pkg;

   localparam int MaxVerticesDefault = 64;
   localparam int CoordBitsDefault   = 16;
   localparam int PortCoordBits      = 16;

   typedef struct packed {
      logic load;   // shift a new vertex in at the head of the chain
      logic rotate; // pass every vertex one cell forward, tail wraps to head
   } shift_ctrl_type;

endpackage

// ===== rtl/pscc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscc_cell
// One vertex slot of the shift chain; takes its neighbor's vertex on a move.
// ----------------------------------------------------------------------------
module pscc_cell
   import pscc_pkg::*;
#(
   parameter int CoordBits = CoordBitsDefault
) (
   input  logic                        clock,
   input  shift_ctrl_type              ctrl,
   input  logic signed [CoordBits-1:0] prev_x,
   input  logic signed [CoordBits-1:0] prev_y,
   output logic signed [CoordBits-1:0] vert_x,
   output logic signed [CoordBits-1:0] vert_y
);

   logic signed [CoordBits-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load || ctrl.rotate) begin
         x_ff <= prev_x;
         y_ff <= prev_y;
      end
   end

   assign vert_x = x_ff;
   assign vert_y = y_ff;

endmodule

// ===== rtl/pscc_pair_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscc_pair_test
// Pipelined segment pair intersection test: differences, products, compares.
// ----------------------------------------------------------------------------
module pscc_pair_test
   import pscc_pkg::*;
#(
   parameter int CoordBits = CoordBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [CoordBits-1:0] ax0, ay0, ax1, ay1,
   input  logic signed [CoordBits-1:0] bx0, by0, bx1, by1,
   output logic                        out_valid,
   output logic                        out_meet
);

   localparam int DW = CoordBits + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   logic signed [DW-1:0] dya_ff, dxa_ff, dyb_ff, dxb_ff, ey_ff, ex_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [SW-1:0] den_in, na_in, nb_in;
   logic                 v1_ff, v2_ff, v3_ff, meet_ff;
   logic                 meet_in;

   always_ff @(posedge clock) begin
      dya_ff <= DW'(ay1) - DW'(ay0);
      dxa_ff <= DW'(ax1) - DW'(ax0);
      dyb_ff <= DW'(by0) - DW'(by1);
      dxb_ff <= DW'(bx0) - DW'(bx1);
      ey_ff  <= DW'(by0) - DW'(ay0);
      ex_ff  <= DW'(bx0) - DW'(ax0);
      p0_ff  <= dya_ff * dxb_ff;
      p1_ff  <= dyb_ff * dxa_ff;
      p2_ff  <= dya_ff * ex_ff;
      p3_ff  <= ey_ff * dxa_ff;
      p4_ff  <= ey_ff * dxb_ff;
      p5_ff  <= dyb_ff * ex_ff;
      meet_ff <= meet_in;
   end

   always_comb begin
      den_in = SW'(p0_ff) - SW'(p1_ff);
      na_in  = SW'(p2_ff) - SW'(p3_ff);
      nb_in  = SW'(p4_ff) - SW'(p5_ff);
      if (den_in == '0)
         meet_in = (na_in == '0) && (nb_in == '0);
      else if (!den_in[SW-1])
         meet_in = !na_in[SW-1] && (na_in <= den_in) && !nb_in[SW-1] && (nb_in <= den_in);
      else
         meet_in = (na_in[SW-1] || (na_in == '0)) && (na_in >= den_in)
                   && (nb_in[SW-1] || (nb_in == '0)) && (nb_in >= den_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_meet  = meet_ff;

endmodule

// ===== rtl/polyline_self_crossing_check_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_self_crossing_check_core
// Open polyline self-crossing check over a ring of vertex cells.
// Loading: one vertex word per cycle while in the load state. The check then
// runs a pick phase over the ring, a sweep of the ring per stored segment, a
// pipeline drain and a send step, which waits for any previous verdict to be
// taken; the next polyline loads from the following cycle.
// Synchronous active-high reset clears the count, overflow and sequencer.
// ----------------------------------------------------------------------------
module polyline_self_crossing_check_core
   import pscc_pkg::*;
#(
   parameter int MaxVertices = MaxVerticesDefault,
   parameter int CoordBits   = CoordBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // coord_x [15:0], coord_y [31:16]
   input  logic        req_tlast,  // last_vertex
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // no_crossing [0], overflowed [1], zero fill
);

   localparam int CW = $clog2(MaxVertices + 1);
   localparam int HW = $clog2(MaxVertices);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_PICK  = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_SEND  = 3'd4;

   logic [2:0]    state_ff;
   logic [CW-1:0] count_ff, outer_ff;
   logic [HW-1:0] head_ff, slot_ff, sweep_ff;
   logic          ovf_ff, hit_ff, rsp_valid_ff;
   logic [1:0]    rsp_data_ff;
   logic [2:0]    drain_ff;
   logic signed [CoordBits-1:0] ax0_ff, ay0_ff, ax1_ff, ay1_ff;
   logic          accept, full, test_valid, meet, test_in;
   logic          head_seg_ok, pair_ok;
   logic [HW-1:0] head_dec;
   logic [CW:0]   head_ext, slot_ext, count_ext;
   shift_ctrl_type ctrl;

   logic signed [CoordBits-1:0] cx [MaxVertices];
   logic signed [CoordBits-1:0] cy [MaxVertices];
   logic signed [CoordBits-1:0] px [MaxVertices];
   logic signed [CoordBits-1:0] py [MaxVertices];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_LOAD);
   assign full       = (count_ff == CW'(MaxVertices));

   assign ctrl.load   = accept && !full;
   assign ctrl.rotate = (state_ff == ST_PICK) || (state_ff == ST_SWEEP);

   // Ring: cell k feeds cell k+1, last cell wraps to the head on rotate.
   genvar g;
   generate
      for (g = 0; g < MaxVertices; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign px[g] = ctrl.load ? CoordBits'(req_tdata[PortCoordBits-1:0])
                                     : cx[MaxVertices-1];
            assign py[g] = ctrl.load ? CoordBits'(req_tdata[2*PortCoordBits-1:PortCoordBits])
                                     : cy[MaxVertices-1];
         end else begin : g_body
            assign px[g] = cx[g-1];
            assign py[g] = cy[g-1];
         end
         pscc_cell #(.CoordBits(CoordBits)) u_cell (
            .clock (clock), .ctrl (ctrl),
            .prev_x(px[g]), .prev_y(py[g]),
            .vert_x(cx[g]), .vert_y(cy[g])
         );
      end
   endgenerate

   // Slot head_ff sits in cell 0; cells 1,0 form a segment when head+1 < count.
   assign head_dec    = (head_ff == '0) ? HW'(MaxVertices - 1) : head_ff - HW'(1);
   assign head_ext    = (CW+1)'(head_ff);
   assign slot_ext    = (CW+1)'(slot_ff);
   assign count_ext   = (CW+1)'(count_ff);
   assign head_seg_ok = (head_ext + (CW+1)'(2)) <= count_ext;
   assign pair_ok     = head_seg_ok && (head_ext >= slot_ext + (CW+1)'(2));
   assign test_in     = (state_ff == ST_SWEEP) && pair_ok;

   pscc_pair_test #(.CoordBits(CoordBits)) u_test (
      .clock(clock), .reset(reset), .in_valid(test_in),
      .ax0(ax0_ff), .ay0(ay0_ff), .ax1(ax1_ff), .ay1(ay1_ff),
      .bx0(cx[1]), .by0(cy[1]), .bx1(cx[0]), .by1(cy[0]),
      .out_valid(test_valid), .out_meet(meet)
   );

   // Pick: hold the segment at the head, then sweep the ring past it once.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         outer_ff     <= '0;
         head_ff      <= '0;
         slot_ff      <= '0;
         sweep_ff     <= '0;
         ovf_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (test_valid && meet) hit_ff <= 1'b1;
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (!full) count_ff <= count_ff + CW'(1);
                  else       ovf_ff   <= 1'b1;
                  if (req_tlast) begin
                     state_ff <= ST_PICK;
                     head_ff  <= '0;
                     outer_ff <= '0;
                     hit_ff   <= 1'b0;
                  end
               end
            end
            ST_PICK: begin
               head_ff  <= head_dec;
               outer_ff <= outer_ff + CW'(1);
               if (head_seg_ok) begin
                  ax0_ff   <= cx[1];
                  ay0_ff   <= cy[1];
                  ax1_ff   <= cx[0];
                  ay1_ff   <= cy[0];
                  slot_ff  <= head_ff;
                  sweep_ff <= '0;
                  state_ff <= ST_SWEEP;
               end else if (outer_ff == CW'(MaxVertices - 1)) begin
                  drain_ff <= 3'd4;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_SWEEP: begin
               head_ff  <= head_dec;
               sweep_ff <= sweep_ff + HW'(1);
               if (sweep_ff == HW'(MaxVertices - 1)) begin
                  if (outer_ff == CW'(MaxVertices)) begin
                     drain_ff <= 3'd4;
                     state_ff <= ST_DRAIN;
                  end else begin
                     state_ff <= ST_PICK;
                  end
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff - 3'd1;
               if (drain_ff == 3'd1) state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {ovf_ff, !hit_ff};
                  count_ff     <= '0;
                  ovf_ff       <= 1'b0;
                  state_ff     <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_tready)
      else $error("input taken during check");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MaxVertices))
      else $error("vertex count beyond store");
   a_rsp_after_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SEND))
      else $error("result without finished check");

endmodule

// ===== dv/polyline_self_crossing_check_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_self_crossing_check_core_tb
// Self-checking bench for the polyline self-crossing check. Random polylines
// of vertex words go in, and each final vertex yields one verdict word. The
// verdict is compared with a local exact-integer predictor, including store
// overflow, short polylines, collinear and crossing shapes.
// ----------------------------------------------------------------------------
module polyline_self_crossing_check_core_tb
   import pscc_pkg::*;
();

   localparam int MaxV      = MaxVerticesDefault;
   localparam int WatchMax  = 40000;

   typedef struct packed {
      logic        last;
      logic [15:0] y;
      logic [15:0] x;
   } vertex_word_type;

   typedef struct packed {
      logic no_crossing;
      logic overflowed;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   polyline_self_crossing_check_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vertex_word_type pending_words[$];
   verdict_type     expected_verdicts[$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              watchdog = 0;
   bit              stim_done = 1'b0;
   bit              hold_off = 1'b0;

   // predictor state
   longint px[MaxV];
   longint py[MaxV];
   int     pcount = 0;
   bit     pover = 1'b0;

   function automatic bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   function automatic bit segs_meet(int a0, int a1, int b0, int b1);
      longint dya, dxa, dyb, dxb, ey, ex, den, na, nb;
      dya = py[a1] - py[a0]; dxa = px[a1] - px[a0];
      dyb = py[b0] - py[b1]; dxb = px[b0] - px[b1];
      ey  = py[b0] - py[a0]; ex  = px[b0] - px[a0];
      den = dya * dxb - dyb * dxa;
      na  = dya * ex - ey * dxa;
      nb  = ey * dxb - dyb * ex;
      if (den == 0) return na == 0 && nb == 0;
      return in_unit(na, den) && in_unit(nb, den);
   endfunction

   task automatic predict_vertex(vertex_word_type w);
      verdict_type v;
      bit clear;
      if (pcount < MaxV) begin
         px[pcount] = longint'($signed(w.x));
         py[pcount] = longint'($signed(w.y));
         pcount++;
      end else begin
         pover = 1'b1;
      end
      if (w.last) begin
         clear = 1'b1;
         for (int i = 1; i + 2 < pcount; i++)
            for (int j = i + 2; j < pcount; j++)
               if (clear && segs_meet(i - 1, i, j - 1, j)) clear = 1'b0;
         v.no_crossing = clear;
         v.overflowed = pover;
         expected_verdicts.insert(expected_verdicts.size(), v);
         pcount = 0;
         pover = 1'b0;
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d",
               what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 15));
         2: return 16'($signed($urandom_range(0, 40)) - 20);
         default: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      endcase
   endfunction

   task automatic add_word(logic [15:0] x, logic [15:0] y, logic last);
      vertex_word_type w;
      w.x = x; w.y = y; w.last = last;
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic add_polyline(int n, int mode);
      for (int k = 0; k < n; k++)
         add_word(rand_coord(mode), rand_coord(mode), k == n - 1);
   endtask

   // idle control: long stretch with no idling in the middle of the run
   function automatic bit idle_now();
      if (cycle_count > 20000 && cycle_count < 60000) return 1'b0;
      return $urandom_range(0, 99) < 28;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() > 0 && !hold_off && !idle_now()) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_words[0].y, pending_words[0].x};
            req_tlast  <= pending_words[0].last;
            predict_vertex(pending_words.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      verdict_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_now();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) watchdog <= 0;
         else watchdog <= watchdog + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected word", int'(rsp_tdata), 0);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata[0] !== want.no_crossing)
                  report_mismatch("no_crossing", int'(rsp_tdata[0]),
                                  int'(want.no_crossing));
               if (rsp_tdata[1] !== want.overflowed)
                  report_mismatch("overflowed", int'(rsp_tdata[1]),
                                  int'(want.overflowed));
               if (rsp_tdata[7:2] !== 6'd0)
                  report_mismatch("fill", int'(rsp_tdata[7:2]), 0);
            end
         end
         if (watchdog >= WatchMax) begin
            $display("polyline_self_crossing_check_core regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int total;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: short polylines
      add_word(16'h0000, 16'h0000, 1'b1);
      add_word(16'h7fff, 16'h8000, 1'b0); add_word(16'h8000, 16'h7fff, 1'b1);
      add_word(16'd0, 16'd0, 1'b0); add_word(16'd5, 16'd0, 1'b0);
      add_word(16'd5, 16'd5, 1'b1);
      // crossing zigzag (bowtie)
      add_word(16'd0, 16'd0, 1'b0); add_word(16'd10, 16'd10, 1'b0);
      add_word(16'd10, 16'd0, 1'b0); add_word(16'd0, 16'd10, 1'b1);
      // non-crossing square path
      add_word(16'd0, 16'd0, 1'b0); add_word(16'd10, 16'd0, 1'b0);
      add_word(16'd10, 16'd10, 1'b0); add_word(16'd0, 16'd10, 1'b1);
      // collinear overlap
      add_word(16'd0, 16'd0, 1'b0); add_word(16'd4, 16'd0, 1'b0);
      add_word(16'd8, 16'd0, 1'b0); add_word(16'd2, 16'd0, 1'b1);
      // extremes
      add_word(16'h8000, 16'h8000, 1'b0); add_word(16'h7fff, 16'h7fff, 1'b0);
      add_word(16'h7fff, 16'h8000, 1'b0); add_word(16'h8000, 16'h7fff, 1'b1);
      total = pending_words.size();
      // store overflow, final vertex dropped too
      add_polyline(MaxV + 3, 2);
      add_polyline(MaxV, 0);
      add_polyline(MaxV + 1, 1);
      total = pending_words.size();
      while (total < 1800) begin
         int n, m;
         m = $urandom_range(0, 99);
         if (m < 85) n = $urandom_range(1, 10);
         else if (m < 97) n = $urandom_range(11, 30);
         else n = $urandom_range(MaxV - 1, MaxV + 2);
         add_polyline(n, $urandom_range(0, 3));
         total += n;
         if (total > 900 && total <= 900 + n) begin
            // drain everything before feeding more
            wait (pending_words.size() == 0);
            hold_off = 1'b1;
            wait (expected_verdicts.size() == 0);
            hold_off = 1'b0;
         end
      end
      wait (pending_words.size() == 0 && expected_verdicts.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("polyline_self_crossing_check_core regression: pass");
      end else begin
         $display("polyline_self_crossing_check_core regression: fail");
      end
      $finish;
   end

endmodule
